### sv/tpq_pkg.sv
// Shared types and constants for the timeout priority queue.
`default_nettype none
package tpq_pkg;
    localparam int CAPACITY    = 32;
    localparam int MAX_EXPIRED = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int EXP_W       = $clog2(MAX_EXPIRED + 1);
    localparam int DL_W        = 33;
    localparam int ID_W        = 10;
    localparam int TMO_W       = 24;
    localparam int NOW_W       = 32;
    localparam int DLY_W       = 25;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;

    localparam logic [1:0] RK_ADD_ACK    = 2'd0;
    localparam logic [1:0] RK_CANCEL_ACK = 2'd1;
    localparam logic [1:0] RK_EXPIRED    = 2'd2;
    localparam logic [1:0] RK_DELAY      = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOID  = 2'd2;

    typedef struct packed {
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] id;
        logic            notify;
        logic            deleted;
    } entry_t;

    // Command broadcast to every cell at once.
    typedef struct packed {
        logic            ins;     // insert new entry
        logic            pop;     // shift whole row toward the head
        logic            cancel;  // mark entries of cmd id deleted
        entry_t          item;
    } cell_cmd_t;
endpackage
`default_nettype wire

### sv/tpq_cell.sv
// One storage cell of the sorted timer row.
`default_nettype none
module tpq_cell (
    input  wire logic              aclk,
    input  wire tpq_pkg::cell_cmd_t cmd,
    input  wire logic              occ,       // this cell holds an entry
    input  wire logic              prev_occ,
    input  wire tpq_pkg::entry_t   prev_ent,  // neighbor toward head
    input  wire logic              prev_le,   // neighbor deadline <= new
    input  wire tpq_pkg::entry_t   next_ent,  // neighbor toward tail
    output tpq_pkg::entry_t        ent,
    output logic                   le,        // occupied and deadline <= new
    output logic                   hit        // live entry matching cancel id
);
    import tpq_pkg::*;
    entry_t ent_reg, ent_next;

    assign ent = ent_reg;
    assign le  = occ && (ent_reg.deadline <= cmd.item.deadline);
    assign hit = occ && !ent_reg.deleted && (ent_reg.id == cmd.item.id);

    always_comb begin
        ent_next = ent_reg;
        if (cmd.ins) begin
            // keep if we stay ahead; take new if boundary; else shift from prev
            if (le) begin
                ent_next = ent_reg;
            end else if (!prev_occ || prev_le) begin
                ent_next = cmd.item;
            end else begin
                ent_next = prev_ent;
            end
        end else if (cmd.pop) begin
            ent_next = next_ent;
        end else if (cmd.cancel && hit) begin
            ent_next.deleted = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end
endmodule
`default_nettype wire

### sv/timeout_priority_queue_top.sv
// Top level: cell row of timers plus the command sequencer.
// Add and cancel: the ack word is valid the cycle after the input word is taken, and a
// new input word is taken every cycle while the ack drains.
// Service: pops head entries one at a time while the output is free, emitting an expired
// word per live notify entry, then loads the delay word and passes S_WAIT before new input.
// Reset (aresetn low, synchronous) empties the row and clears the output.
`default_nettype none
module timeout_priority_queue_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: conn_id[9:0], timeout_ms[33:10], notify[34], now_ms[66:35], pad
    input  wire logic [71:0] s_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: expired_id[9:0], delay_ms[34:10], status[36:35], pad
    output logic [39:0]      m_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import tpq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SERVE, S_WAIT} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [EXP_W-1:0]  nexp_reg;
    logic [NOW_W-1:0]  now_reg;
    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic [DLY_W-1:0]  m_dly_reg;
    logic [1:0]        m_st_reg;
    logic              m_last_reg;

    logic [1:0]        in_kind;
    logic [ID_W-1:0]   in_id;
    logic [TMO_W-1:0]  in_tmo;
    logic              in_ntf;
    logic [NOW_W-1:0]  in_now;
    assign in_kind = s_tuser;
    assign in_id   = s_tdata[9:0];
    assign in_tmo  = s_tdata[33:10];
    assign in_ntf  = s_tdata[34];
    assign in_now  = s_tdata[66:35];

    // The output word is free when empty or being taken this cycle.
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    logic acc;
    assign acc = s_tvalid && s_tready;

    cell_cmd_t        cmd;
    entry_t           ents [CAPACITY];
    logic [CAPACITY-1:0] les, hits, occs;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            entry_t pe, ne;
            logic   po, pl;
            assign occs[g] = (CNT_W'(g) < count_reg);
            if (g == 0) begin : g_h
                assign pe = cmd.item;
                assign po = 1'b0;
                assign pl = 1'b0;
            end else begin : g_m
                assign pe = ents[g-1];
                assign po = occs[g-1];
                assign pl = les[g-1];
            end
            if (g == CAPACITY - 1) begin : g_t
                assign ne = ents[g];
            end else begin : g_n
                assign ne = ents[g+1];
            end
            tpq_cell u_cell (
                .aclk     (aclk),
                .cmd      (cmd),
                .occ      (occs[g]),
                .prev_occ (po),
                .prev_ent (pe),
                .prev_le  (pl),
                .next_ent (ne),
                .ent      (ents[g]),
                .le       (les[g]),
                .hit      (hits[g])
            );
        end
    endgenerate

    // Head examination during service.
    entry_t head;
    logic   empty, full, head_exp;
    logic [DL_W-1:0] diff;
    assign head     = ents[0];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign head_exp = head.deadline <= {1'b0, now_reg};
    assign diff     = head.deadline - {1'b0, now_reg};

    // Close the service run with the delay word, or emit an expired word.
    logic serve_close, serve_emit, out_load;
    assign serve_close = empty || (!head.deleted && !head_exp) ||
                         (!head.deleted && head.notify &&
                          nexp_reg >= EXP_W'(MAX_EXPIRED));
    assign serve_emit  = !serve_close && !head.deleted && head.notify;
    // A new output word is loaded this cycle.
    assign out_load = ((state_reg == S_IDLE) && acc &&
                       (in_kind == KIND_ADD || in_kind == KIND_CANCEL)) ||
                      ((state_reg == S_SERVE) && out_free && (serve_close || serve_emit));

    logic do_ins, do_cancel, do_pop;
    always_comb begin
        do_ins    = acc && (in_kind == KIND_ADD) && !full;
        do_cancel = acc && (in_kind == KIND_CANCEL);
        do_pop    = 1'b0;
        if (state_reg == S_SERVE && out_free && !empty) begin
            if (head.deleted) begin
                do_pop = 1'b1;
            end else if (head_exp) begin
                if (!head.notify) begin
                    do_pop = 1'b1;
                end else if (nexp_reg < EXP_W'(MAX_EXPIRED)) begin
                    do_pop = 1'b1;
                end
            end
        end
        cmd.ins            = do_ins;
        cmd.pop            = do_pop;
        cmd.cancel         = do_cancel;
        cmd.item.deadline  = {1'b0, in_now} + DL_W'(in_tmo);
        cmd.item.id        = in_id;
        cmd.item.notify    = in_ntf;
        cmd.item.deleted   = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            nexp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            if (do_ins) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        now_reg  <= in_now;
                        nexp_reg <= '0;
                        m_id_reg <= in_id;
                        m_dly_reg <= '0;
                        m_last_reg <= 1'b1;
                        if (in_kind == KIND_ADD) begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= RK_ADD_ACK;
                            m_st_reg    <= full ? ST_FULL : ST_OK;
                        end else if (in_kind == KIND_CANCEL) begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= RK_CANCEL_ACK;
                            m_st_reg    <= (|hits) ? ST_OK : ST_NOID;
                        end else begin
                            state_reg <= S_SERVE;
                        end
                    end
                end
                S_SERVE: begin
                    if (out_free) begin
                        if (serve_close) begin
                            // close the run with the delay word
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= RK_DELAY;
                            m_id_reg    <= '0;
                            m_st_reg    <= ST_OK;
                            m_last_reg  <= 1'b1;
                            if (empty) begin
                                m_dly_reg <= '1;
                            end else if (head_exp) begin
                                m_dly_reg <= '0;
                            end else if (diff > DL_W'(24'hFFFFFF)) begin
                                m_dly_reg <= DLY_W'(24'hFFFFFF);
                            end else begin
                                m_dly_reg <= DLY_W'(diff);
                            end
                            state_reg <= S_WAIT;
                        end else if (serve_emit) begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= RK_EXPIRED;
                            m_id_reg    <= head.id;
                            m_dly_reg   <= '0;
                            m_st_reg    <= ST_OK;
                            m_last_reg  <= 1'b0;
                            nexp_reg    <= nexp_reg + 1'b1;
                        end
                    end
                end
                S_WAIT: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_st_reg, m_dly_reg, m_id_reg};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");
    a_no_ins_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins && cmd.pop))
        else $error("insert and pop together");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !empty)
        else $error("pop on empty row");
    a_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("input taken outside idle");
`endif
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the timeout priority queue: model, stimulus and scoreboard.
`timescale 1ns / 1ps
module testbench;
    import tpq_pkg::*;

    localparam logic [1:0] KIND_SERVICE = 2'd2;
    localparam logic [1:0] KIND_ODD     = 2'd3;

    localparam int PH_FREE    = 0;
    localparam int PH_SRC_GAP = 1;
    localparam int PH_SNK_GAP = 2;
    localparam int PH_BOTH    = 3;

    typedef struct packed {
        logic [1:0]       rkind;
        logic [ID_W-1:0]  id;
        logic [DLY_W-1:0] delay;
        logic [1:0]       status;
        logic             last;
    } timer_word_t;

    // Predicts the block's words and checks each output word against them.
    class timer_scoreboard;
        entry_t        rows[$];
        timer_word_t   pending[$];
        int            errors;

        function void push(logic [1:0] rk, logic [ID_W-1:0] id, logic [DLY_W-1:0] d,
                           logic [1:0] st, logic lst);
            timer_word_t w;
            w.rkind = rk; w.id = id; w.delay = d; w.status = st; w.last = lst;
            pending.push_back(w);
        endfunction

        // Note an accepted input word and work out the words it causes.
        function void note_input(logic [1:0] kind, logic [ID_W-1:0] id,
                                 logic [TMO_W-1:0] tmo, logic ntf, logic [NOW_W-1:0] now);
            entry_t e;
            logic [DL_W-1:0] dl;
            logic [DL_W-1:0] diff;
            logic [DLY_W-1:0] dly;
            int p;
            int n;
            bit found;
            if (kind == KIND_ADD) begin
                if (rows.size() >= CAPACITY) begin
                    push(RK_ADD_ACK, id, '0, ST_FULL, 1'b1);
                end else begin
                    dl = DL_W'(now) + DL_W'(tmo);
                    p = 0;
                    while (p < rows.size() && rows[p].deadline <= dl) p++;
                    e.deadline = dl; e.id = id; e.notify = ntf; e.deleted = 1'b0;
                    rows.insert(p, e);
                    push(RK_ADD_ACK, id, '0, ST_OK, 1'b1);
                end
            end else if (kind == KIND_CANCEL) begin
                found = 0;
                foreach (rows[i])
                    if (!rows[i].deleted && rows[i].id == id) begin
                        rows[i].deleted = 1'b1;
                        found = 1;
                    end
                push(RK_CANCEL_ACK, id, '0, found ? ST_OK : ST_NOID, 1'b1);
            end else begin
                // Service: purge deleted heads, pop expired ones, report the rest.
                n = 0;
                dly = '1;
                while (rows.size() > 0) begin
                    if (rows[0].deleted) begin
                        void'(rows.pop_front());
                        continue;
                    end
                    if (rows[0].deadline > DL_W'(now)) begin
                        diff = rows[0].deadline - DL_W'(now);
                        dly = (diff > 33'hFFFFFF) ? 25'hFFFFFF : diff[DLY_W-1:0];
                        break;
                    end
                    if (rows[0].notify) begin
                        if (n >= MAX_EXPIRED) begin
                            dly = '0;
                            break;
                        end
                        push(RK_EXPIRED, rows[0].id, '0, ST_OK, 1'b0);
                        n++;
                    end
                    void'(rows.pop_front());
                end
                push(RK_DELAY, '0, dly, ST_OK, 1'b1);
            end
        endfunction

        // Compare one output word with the oldest expected word.
        function void check_word(timer_word_t got);
            timer_word_t w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.rkind != w.rkind)
                $display("%0t: result_kind expected %0d actual %0d", $time, w.rkind, got.rkind);
            if (got.id != w.id)
                $display("%0t: expired_id expected %0d actual %0d", $time, w.id, got.id);
            if (got.delay != w.delay)
                $display("%0t: delay_ms expected %0d actual %0d", $time,
                         $signed(w.delay), $signed(got.delay));
            if (got.status != w.status)
                $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
            if (got.last != w.last)
                $display("%0t: last expected %0d actual %0d", $time, w.last, got.last);
            if (got != w) errors++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // conn_id, timeout_ms, notify, now_ms, pad
    logic [1:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // expired_id, delay_ms, status, pad
    logic [1:0]  m_tuser;   // result_kind
    logic        m_tlast;

    timer_scoreboard board;
    int              phase;
    logic [NOW_W-1:0] clock_ms;

    timeout_priority_queue_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: stall at random per phase, check every accepted word.
    always @(posedge aclk) begin
        timer_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.rkind  = m_tuser;
            got.id     = m_tdata[9:0];
            got.delay  = m_tdata[34:10];
            got.status = m_tdata[36:35];
            got.last   = m_tlast;
            board.check_word(got);
        end
        if (!aresetn)
            m_tready <= 1'b0;
        else if (phase == PH_SNK_GAP)
            m_tready <= ($urandom_range(99) >= 82);
        else if (phase == PH_BOTH)
            m_tready <= ($urandom_range(99) >= 10);
        else
            m_tready <= 1'b1;
    end

    // Send one word, idling beforehand as the phase asks, and hold until accepted.
    // Valid stays high after acceptance so a following word can go back to back.
    task automatic send_word(logic [1:0] kind, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo,
                             logic ntf, logic [NOW_W-1:0] now);
        int gap;
        gap = 0;
        if (phase == PH_SRC_GAP)
            while ($urandom_range(99) < 82) gap++;
        else if (phase == PH_BOTH)
            while ($urandom_range(99) < 10) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, now, ntf, tmo, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(kind, id, tmo, ntf, now);
    endtask

    // Add, cancel and service with mostly small timeouts around a moving clock.
    task automatic random_word();
        int r;
        logic [ID_W-1:0] id;
        r  = $urandom_range(99);
        id = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(15));
        if (r < 50)
            send_word(KIND_ADD, id,
                      ($urandom_range(9) == 0) ? TMO_W'($urandom) : TMO_W'($urandom_range(300)),
                      $urandom_range(3) != 0, clock_ms);
        else if (r < 70)
            send_word(KIND_CANCEL, id, TMO_W'($urandom), 1'($urandom), clock_ms);
        else begin
            clock_ms = clock_ms + $urandom_range(200);
            send_word(($urandom_range(9) == 0) ? KIND_ODD : KIND_SERVICE, id,
                      TMO_W'($urandom), 1'($urandom), clock_ms);
        end
    endtask

    initial begin
        int wait_cycles;
        board    = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_ADD;
        phase    = PH_FREE;
        clock_ms = 32'd1000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty service, unknown cancel, extremes of the fields.
        send_word(KIND_SERVICE, '0, '0, 1'b0, '0);
        send_word(KIND_CANCEL, 10'h3FF, '0, 1'b0, '0);
        send_word(KIND_ADD, 10'h3FF, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF);
        send_word(KIND_ADD, 10'd5, 24'd10, 1'b1, 32'd0);
        send_word(KIND_ADD, 10'd6, 24'd10, 1'b1, 32'd0);     // tie, insertion order
        send_word(KIND_ADD, 10'd5, 24'd20, 1'b0, 32'd0);     // repeated id
        send_word(KIND_ADD, 10'd7, 24'd5, 1'b0, 32'd0);      // silent expiry
        send_word(KIND_SERVICE, '0, '0, 1'b0, 32'd3);
        send_word(KIND_CANCEL, 10'd5, '0, 1'b0, 32'd3);      // both entries of id 5
        send_word(KIND_ODD, '0, '0, 1'b0, 32'd15);           // kind 3 acts as service
        send_word(KIND_SERVICE, '0, '0, 1'b0, 32'd0);        // clock going back, saturate
        send_word(KIND_SERVICE, '0, '0, 1'b0, 32'hFFFFFFFF); // far entry still pending
        // Fill past capacity with expired notify entries: full status and long service.
        for (int i = 0; i < CAPACITY + 1; i++)
            send_word(KIND_ADD, ID_W'(i), TMO_W'(i), 1'b1, 32'd100);
        send_word(KIND_SERVICE, '0, '0, 1'b0, 32'd500);
        send_word(KIND_SERVICE, '0, '0, 1'b0, 32'd500);

        for (int p = 0; p < 4; p++) begin
            phase = p;
            for (int i = 0; i < 32; i++) random_word();
        end
        phase = PH_FREE;
        send_word(KIND_SERVICE, '0, '0, 1'b0, 32'hFFFFFFFF);
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (50) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
